@@ sv/ose_pkg.sv @@
// shared constants, types and helpers for the opaque span extractor
package ose_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int INDEX_BITS    = 20;
    localparam int COUNT_BITS    = 20;
    localparam int LEN_BITS      = 11;
    localparam int WIDTH_BITS    = 11;
    localparam int PIX_BITS      = 8;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int SPAN_BITS     = INDEX_BITS + LEN_BITS + COUNT_BITS;
    localparam int M_DATA_BITS   = ((SPAN_BITS + 7) / 8) * 8;
    localparam int S_DATA_BITS   = ((PIX_BITS + 7) / 8) * 8;

    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(320);
    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX   = WIDTH_BITS'(MAX_WIDTH);

    // one pixel word as held in the input register
    typedef struct packed {
        logic [PIX_BITS-1:0] pixel;
        logic                last_pixel;
    } t_pixel_word;

    // one span result
    typedef struct packed {
        logic [COUNT_BITS-1:0] span_number;
        logic [LEN_BITS-1:0]   span_length;
        logic [INDEX_BITS-1:0] span_start;
    } t_span;

    // clamp the programmed width to 1..MAX_WIDTH
    function automatic logic [WIDTH_BITS-1:0] eff_width(input logic [WIDTH_BITS-1:0] w);
        logic [WIDTH_BITS-1:0] r;
        if (w == '0) begin
            r = WIDTH_BITS'(1);
        end else if (w > WIDTH_MAX) begin
            r = WIDTH_MAX;
        end else begin
            r = w;
        end
        return r;
    endfunction

endpackage

@@ sv/ose_in_stage.sv @@
// input register stage for pixel words
module ose_in_stage
    import ose_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_pixel_word i_word,
    input  logic        i_take,
    output logic        o_valid,
    output t_pixel_word o_word
);

    logic        r_valid;
    t_pixel_word r_word;

    // accept when empty or when the held word moves on this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

endmodule

@@ sv/ose_span_core.sv @@
// span detection state, width register and next-state logic
module ose_span_core
    import ose_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [WIDTH_BITS-1:0] i_cfg_data,
    input  logic                  i_step,
    input  t_pixel_word           i_word,
    output logic                  o_hit,
    output t_span                 o_span
);

    logic [WIDTH_BITS-1:0] r_width;
    logic [INDEX_BITS-1:0] r_pos;
    logic [COL_BITS-1:0]   r_col;
    logic [PIX_BITS-1:0]   r_key;
    logic [LEN_BITS-1:0]   r_run;
    logic [COUNT_BITS-1:0] r_cnt;

    logic [INDEX_BITS-1:0] n_pos;
    logic [COL_BITS-1:0]   n_col;
    logic [PIX_BITS-1:0]   n_key;
    logic [LEN_BITS-1:0]   n_run;
    logic [COUNT_BITS-1:0] n_cnt;

    logic [WIDTH_BITS-1:0] w_eff;
    logic                  row_end;
    logic                  opaque;
    logic [LEN_BITS-1:0]   run_inc;
    logic [INDEX_BITS-1:0] run_ext;

    // width register; the user must write it only while idle, the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
        end else if (i_cfg_valid) begin
            r_width <= i_cfg_data;
        end
    end

    // classify the pixel and decide whether a run closes
    always_comb begin
        w_eff   = eff_width(r_width);
        row_end = (WIDTH_BITS'(r_col) + WIDTH_BITS'(1)) >= w_eff;
        n_key   = (r_pos == '0) ? i_word.pixel : r_key;
        opaque  = i_word.pixel != n_key;
        run_inc = opaque ? r_run + LEN_BITS'(1) : r_run;
        run_ext = INDEX_BITS'(run_inc);
        o_hit   = (run_inc != '0) && (!opaque || row_end || i_word.last_pixel);

        o_span.span_start  = opaque ? (r_pos + INDEX_BITS'(1) - run_ext) : (r_pos - run_ext);
        o_span.span_length = run_inc;
        o_span.span_number = r_cnt;

        if (i_word.last_pixel) begin
            n_pos = '0;
            n_col = '0;
            n_run = '0;
            n_cnt = '0;
        end else begin
            n_pos = r_pos + INDEX_BITS'(1);
            n_col = row_end ? '0 : r_col + COL_BITS'(1);
            n_run = (o_hit || row_end) ? '0 : run_inc;
            n_cnt = o_hit ? r_cnt + COUNT_BITS'(1) : r_cnt;
        end
    end

    // image state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_col <= '0;
            r_key <= '0;
            r_run <= '0;
            r_cnt <= '0;
        end else if (i_step) begin
            r_pos <= n_pos;
            r_col <= n_col;
            r_key <= n_key;
            r_run <= n_run;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ sv/ose_out_stage.sv @@
// result register holding one span word for the output side
module ose_out_stage
    import ose_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic                   i_hit,
    input  t_span                  i_span,
    output logic                   o_free,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [M_DATA_BITS-1:0] o_data
);

    logic  r_valid;
    t_span r_span;

    // room for a new word when empty or being taken now
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = M_DATA_BITS'(r_span);

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_hit;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load && i_hit) begin
            r_span <= i_span;
        end
    end

endmodule

@@ sv/opaque_span_extractor.sv @@
// top level of the opaque span extractor
//  channel | dir | handshake                     | payload
//  s_      | in  | s_tvalid / s_tready           | s_tdata = pixel, s_tlast = last_pixel
//  m_      | out | m_tvalid / m_tready           | m_tdata = span_start, span_length, span_number
//  cfg     | in  | i_cfg_valid / o_cfg_ready     | i_cfg_data = image_width
// one pixel per cycle sustained while the output side is not stalled; an accepted pixel
// goes to the input register, then through the span logic into the result register
// the per-pixel state update is combinational, registered when the held word advances
// synchronous active-low reset clears the valid flags and span state, width returns to 320
// a stalled output holds its word; input keeps flowing while the result register can move
module opaque_span_extractor
    import ose_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_DATA_BITS-1:0] s_tdata,   // [7:0] pixel
    input  logic                   s_tlast,   // last_pixel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_BITS-1:0] m_tdata,   // [19:0] span_start, [30:20] span_length,
                                              // [50:31] span_number, rest zero
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [WIDTH_BITS-1:0]  i_cfg_data
);

    t_pixel_word in_word;
    t_pixel_word held_word;
    logic        held_valid;
    logic        out_free;
    logic        advance;
    logic        hit;
    t_span       span;

    assign in_word.pixel      = s_tdata[PIX_BITS-1:0];
    assign in_word.last_pixel = s_tlast;
    assign o_cfg_ready        = 1'b1;

    // held word moves into the span logic when the result side has room
    assign advance = held_valid && out_free;

    ose_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_word  (in_word),
        .i_take  (advance),
        .o_valid (held_valid),
        .o_word  (held_word)
    );

    ose_span_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_step      (advance),
        .i_word      (held_word),
        .o_hit       (hit),
        .o_span      (span)
    );

    ose_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_hit   (hit),
        .i_span  (span),
        .o_free  (out_free),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_data  (m_tdata)
    );

endmodule

@@ sv/ose_checker.sv @@
// port-level checks for the opaque span extractor, bound to the top level
module ose_checker
    import ose_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [M_DATA_BITS-1:0] m_tdata
);

    logic [LEN_BITS-1:0]   len;
    logic [COUNT_BITS-1:0] num;

    assign len = m_tdata[INDEX_BITS +: LEN_BITS];
    assign num = m_tdata[INDEX_BITS+LEN_BITS +: COUNT_BITS];

    // no word shows right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("output word valid right after reset");

    // a stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // span length lies within one row
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (len != '0) && (len <= LEN_BITS'(MAX_WIDTH)))
        else $error("span length out of range");

    // span numbers count up, or restart with a new image
    a_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tready ##1 m_tvalid |->
            (num == '0) || (num == $past(num) + COUNT_BITS'(1)))
        else $error("span number skipped");

    // a free output side never blocks the input
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output side is ready");

endmodule

bind opaque_span_extractor ose_checker u_ose_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
